// ===== rtl/scc_pkg.sv =====
`default_nettype none

package scc_pkg;

    localparam int CURSOR_DEPTH = 256;
    localparam int CURSOR_AW    = 8;

    localparam logic OP_PIXEL  = 1'b0;
    localparam logic OP_CURSOR = 1'b1;

    localparam logic [1:0] FMT_32BPP  = 2'd0;
    localparam logic [1:0] FMT_24BPP  = 2'd1;
    localparam logic [1:0] FMT_RGB565 = 2'd2;

    localparam logic [2:0] REG_SCREEN_WIDTH    = 3'd0;
    localparam logic [2:0] REG_SCREEN_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_LINE_BYTES      = 3'd2;
    localparam logic [2:0] REG_PIXEL_FORMAT    = 3'd3;
    localparam logic [2:0] REG_FRAME_BASE      = 3'd4;
    localparam logic [2:0] REG_CURSOR_COL      = 3'd5;
    localparam logic [2:0] REG_CURSOR_ROW      = 3'd6;
    localparam logic [2:0] REG_TRANSPARENT_KEY = 3'd7;

    typedef struct packed {
        logic        opcode;
        logic [31:0] pixel_value;
        logic [7:0]  cursor_index;
    } item_t;

    typedef struct packed {
        logic [31:0] fb_address;
        logic [31:0] out_data;
        logic [2:0]  byte_count;
        logic        frame_end;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/scc_cursor_ram.sv =====
`default_nettype none

module scc_cursor_ram
    import scc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [CURSOR_AW-1:0] waddr,
    input  wire logic [31:0]          wdata,
    input  wire logic                 re,
    input  wire logic [CURSOR_AW-1:0] raddr,
    output logic      [31:0]          rdata
);

    logic [31:0] mem [CURSOR_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/scanout_cursor_format_convert.sv =====
`default_nettype none

// Channel  | Signals                                   | Carries
// ---------+-------------------------------------------+-------------------------------
// item     | item_valid, item_ready, item (item_t)     | frame pixel or cursor word
// result   | result_valid, result_ready, result        | address, data, bytes, frame end
// config   | cfg_we, cfg_index, cfg_wdata              | register writes, no read-back
//
// One beat per clock sustained while result_ready holds. A pixel beat passes
// through an input stage (cursor store read, position bookkeeping) and then a
// result stage (overlay, format, address add), each of them registered.
// Cursor writes retire at acceptance and produce no result beat.
// Reset restores the register defaults and clears the position counters; the
// cursor store is not cleared. A stalled result holds the input stage, and
// item_ready drops only while both stages are full.
module scanout_cursor_format_convert
    import scc_pkg::*;
#(
    parameter int CURSOR_W = 16,
    parameter int CURSOR_H = 16,
    parameter int MAX_DIM  = 4096
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire item_t       item,
    output logic             result_valid,
    input  wire logic        result_ready,
    output result_t          result,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    localparam int CW    = $clog2(MAX_DIM);
    localparam int WD    = $clog2(MAX_DIM + 1);
    localparam int CMP_W = (WD > 13) ? WD : 13;
    localparam int IW    = 13;

    // configuration
    logic [12:0] screen_width_reg;
    logic [12:0] screen_height_reg;
    logic [14:0] line_bytes_reg;
    logic [1:0]  pixel_format_reg;
    logic [31:0] frame_base_reg;
    logic [11:0] cursor_col_reg;
    logic [11:0] cursor_row_reg;
    logic [31:0] transparent_key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg    <= 13'd640;
            screen_height_reg   <= 13'd480;
            line_bytes_reg      <= 15'd2560;
            pixel_format_reg    <= FMT_32BPP;
            frame_base_reg      <= '0;
            cursor_col_reg      <= '0;
            cursor_row_reg      <= '0;
            transparent_key_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:    screen_width_reg    <= cfg_wdata[12:0];
                REG_SCREEN_HEIGHT:   screen_height_reg   <= cfg_wdata[12:0];
                REG_LINE_BYTES:      line_bytes_reg      <= cfg_wdata[14:0];
                REG_PIXEL_FORMAT:    pixel_format_reg    <= cfg_wdata[1:0];
                REG_FRAME_BASE:      frame_base_reg      <= cfg_wdata;
                REG_CURSOR_COL:      cursor_col_reg      <= cfg_wdata[11:0];
                REG_CURSOR_ROW:      cursor_row_reg      <= cfg_wdata[11:0];
                REG_TRANSPARENT_KEY: transparent_key_reg <= cfg_wdata;
                default:             ;
            endcase
        end
    end

    // position state
    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;
    logic [31:0]   line_off_reg, line_off_next;

    // input stage
    logic          s1_valid_reg, s1_valid_next;
    logic [31:0]   s1_pix_reg;
    logic          s1_hit_reg;
    logic [CW-1:0] s1_col_reg;
    logic [31:0]   s1_base_reg;
    logic          s1_last_reg;
    logic [31:0]   cursor_word;

    // result stage
    logic          result_valid_reg, result_valid_next;
    result_t       result_reg;

    logic          s2_free;
    logic          accept;
    logic          pix_acc;
    logic          wr_acc;

    logic [CMP_W-1:0] w_eff, h_eff;
    logic [CMP_W-1:0] col_ext, row_ext, ccol_ext, crow_ext;
    logic [CMP_W-1:0] dc, dr;
    logic [IW-1:0]    idx;
    logic             line_end, frame_last, on_screen, in_win, hit;

    assign s2_free    = !result_valid_reg || result_ready;
    assign item_ready = !s1_valid_reg || s2_free;
    assign accept     = item_valid && item_ready;
    assign pix_acc    = accept && (item.opcode == OP_PIXEL);
    assign wr_acc     = accept && (item.opcode == OP_CURSOR);

    // a zero size acts as one, an oversized one is clamped
    always_comb
    begin
        if (screen_width_reg == '0)
        begin
            w_eff = CMP_W'(1);
        end
        else if (CMP_W'(screen_width_reg) > CMP_W'(MAX_DIM))
        begin
            w_eff = CMP_W'(MAX_DIM);
        end
        else
        begin
            w_eff = CMP_W'(screen_width_reg);
        end

        if (screen_height_reg == '0)
        begin
            h_eff = CMP_W'(1);
        end
        else if (CMP_W'(screen_height_reg) > CMP_W'(MAX_DIM))
        begin
            h_eff = CMP_W'(MAX_DIM);
        end
        else
        begin
            h_eff = CMP_W'(screen_height_reg);
        end
    end

    always_comb
    begin
        col_ext  = CMP_W'(col_reg);
        row_ext  = CMP_W'(row_reg);
        ccol_ext = CMP_W'(cursor_col_reg);
        crow_ext = CMP_W'(cursor_row_reg);

        line_end   = (col_ext + CMP_W'(1)) >= w_eff;
        frame_last = line_end && ((row_ext + CMP_W'(1)) >= h_eff);

        on_screen = (ccol_ext < w_eff) && (crow_ext < h_eff);
        dc        = col_ext - ccol_ext;
        dr        = row_ext - crow_ext;
        idx       = IW'(dr[IW-1:0] * IW'(CURSOR_W)) + dc[IW-1:0];
        // window entries past the store count as transparent
        in_win    = (col_ext >= ccol_ext) && (row_ext >= crow_ext)
                    && (dc < CMP_W'(CURSOR_W)) && (dr < CMP_W'(CURSOR_H))
                    && (idx < IW'(CURSOR_DEPTH));
        hit       = on_screen && in_win;

        col_next      = col_reg;
        row_next      = row_reg;
        line_off_next = line_off_reg;
        if (pix_acc)
        begin
            if (!line_end)
            begin
                col_next = col_reg + CW'(1);
            end
            else
            begin
                col_next = '0;
                if (frame_last)
                begin
                    row_next      = '0;
                    line_off_next = '0;
                end
                else
                begin
                    row_next      = row_reg + CW'(1);
                    line_off_next = line_off_reg + 32'(line_bytes_reg);
                end
            end
        end
    end

    scc_cursor_ram u_cursor_ram (
        .clk   (clk),
        .we    (wr_acc),
        .waddr (item.cursor_index),
        .wdata (item.pixel_value),
        .re    (pix_acc),
        .raddr (idx[CURSOR_AW-1:0]),
        .rdata (cursor_word)
    );

    // result stage logic
    logic [31:0] pix_sel;
    logic [31:0] fmt_data;
    logic [2:0]  fmt_bytes;
    logic [31:0] col_bytes;
    result_t     result_next;

    always_comb
    begin
        pix_sel = (s1_hit_reg && (cursor_word != transparent_key_reg))
                  ? cursor_word : s1_pix_reg;

        case (pixel_format_reg)
            FMT_24BPP:
            begin
                fmt_data  = {8'd0, pix_sel[23:0]};
                fmt_bytes = 3'd3;
                col_bytes = (32'(s1_col_reg) << 1) + 32'(s1_col_reg);
            end
            FMT_RGB565:
            begin
                fmt_data  = {16'd0, pix_sel[23:19], pix_sel[15:10], pix_sel[7:3]};
                fmt_bytes = 3'd2;
                col_bytes = 32'(s1_col_reg) << 1;
            end
            default:
            begin
                // unused code falls back to 32 bpp
                fmt_data  = pix_sel;
                fmt_bytes = 3'd4;
                col_bytes = 32'(s1_col_reg) << 2;
            end
        endcase

        result_next.fb_address = s1_base_reg + col_bytes;
        result_next.out_data   = fmt_data;
        result_next.byte_count = fmt_bytes;
        result_next.frame_end  = s1_last_reg;

        s1_valid_next     = item_ready ? pix_acc : s1_valid_reg;
        result_valid_next = s2_free ? s1_valid_reg : result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg          <= '0;
            row_reg          <= '0;
            line_off_reg     <= '0;
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg          <= col_next;
            row_reg          <= row_next;
            line_off_reg     <= line_off_next;
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            s1_pix_reg  <= item.pixel_value;
            s1_hit_reg  <= hit;
            s1_col_reg  <= col_reg;
            s1_base_reg <= frame_base_reg + line_off_reg;
            s1_last_reg <= frame_last;
        end
        if (s2_free && s1_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_line_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        pix_acc && line_end |=> col_reg == '0)
        else $error("column did not wrap at line end");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        pix_acc && frame_last |=> (row_reg == '0) && (line_off_reg == '0))
        else $error("row or line offset did not clear at frame end");

    a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && result_valid_reg && !result_ready |-> !item_ready)
        else $error("beat accepted while both stages are full");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        wr_acc |=> !s1_valid_reg)
        else $error("cursor write entered the pixel path");

endmodule

`default_nettype wire

// ===== tb/sv/scanout_beat_checker.sv =====
`timescale 1ns / 1ps

module scanout_beat_checker
    import scc_pkg::*;
#(
    parameter int CURSOR_W = 16,
    parameter int CURSOR_H = 16,
    parameter int MAX_DIM  = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_ready,
    input  item_t       item,
    input  logic        result_valid,
    input  logic        result_ready,
    input  result_t     result,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    output int          mismatches,
    output int          outstanding
);

    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [14:0] line_bytes_reg;
    logic [1:0]  format_reg;
    logic [31:0] base_reg;
    logic [11:0] cur_col_reg;
    logic [11:0] cur_row_reg;
    logic [31:0] key_reg;

    logic [11:0] col_pos;
    logic [11:0] row_pos;
    logic [31:0] line_start;
    logic [31:0] cursor_words [CURSOR_DEPTH];

    result_t     expected_beats [$];
    int          fail_count;

    function automatic logic [12:0] clamp_dim(input logic [12:0] v);
        if (v == 13'd0)
            return 13'd1;
        if (v > MAX_DIM)
            return 13'(MAX_DIM);
        return v;
    endfunction

    // Compute the beat for one frame pixel and advance the raster position.
    function automatic result_t predict_scanout_beat(input logic [31:0] frame_pix);
        logic [12:0] w;
        logic [12:0] h;
        logic [31:0] pix;
        int unsigned dc;
        int unsigned dr;
        int unsigned idx;
        logic        line_end;
        logic        last_pix;
        result_t     beat;

        w   = clamp_dim(width_reg);
        h   = clamp_dim(height_reg);
        pix = frame_pix;

        if (cur_col_reg < w && cur_row_reg < h
            && col_pos >= cur_col_reg && row_pos >= cur_row_reg)
        begin
            dc = col_pos - cur_col_reg;
            dr = row_pos - cur_row_reg;
            if (dc < CURSOR_W && dr < CURSOR_H)
            begin
                idx = dr * CURSOR_W + dc;
                if (idx < CURSOR_DEPTH && cursor_words[idx] != key_reg)
                    pix = cursor_words[idx];
            end
        end

        case (format_reg)
            FMT_24BPP:
            begin
                beat.out_data   = {8'h00, pix[23:0]};
                beat.byte_count = 3'd3;
            end
            FMT_RGB565:
            begin
                beat.out_data   = {16'h0000, pix[23:19], pix[15:10], pix[7:3]};
                beat.byte_count = 3'd2;
            end
            default:
            begin
                beat.out_data   = pix;
                beat.byte_count = 3'd4;
            end
        endcase

        beat.fb_address = base_reg + line_start + col_pos * beat.byte_count;
        line_end        = ({1'b0, col_pos} + 13'd1 >= w);
        last_pix        = line_end && ({1'b0, row_pos} + 13'd1 >= h);
        beat.frame_end  = last_pix;

        if (!line_end)
            col_pos = col_pos + 12'd1;
        else
        begin
            col_pos = '0;
            if (last_pix)
            begin
                row_pos    = '0;
                line_start = '0;
            end
            else
            begin
                row_pos    = row_pos + 12'd1;
                line_start = line_start + 32'(line_bytes_reg);
            end
        end
        return beat;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t ns: %s expected %h, got %h", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;

        if (!rst_n)
        begin
            width_reg      = 13'd640;
            height_reg     = 13'd480;
            line_bytes_reg = 15'd2560;
            format_reg     = FMT_32BPP;
            base_reg       = '0;
            cur_col_reg    = '0;
            cur_row_reg    = '0;
            key_reg        = '0;
            col_pos        = '0;
            row_pos        = '0;
            line_start     = '0;
            expected_beats.delete();
            fail_count     = 0;
            mismatches     <= 0;
            outstanding    <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SCREEN_WIDTH:    width_reg      = cfg_wdata[12:0];
                    REG_SCREEN_HEIGHT:   height_reg     = cfg_wdata[12:0];
                    REG_LINE_BYTES:      line_bytes_reg = cfg_wdata[14:0];
                    REG_PIXEL_FORMAT:    format_reg     = cfg_wdata[1:0];
                    REG_FRAME_BASE:      base_reg       = cfg_wdata;
                    REG_CURSOR_COL:      cur_col_reg    = cfg_wdata[11:0];
                    REG_CURSOR_ROW:      cur_row_reg    = cfg_wdata[11:0];
                    REG_TRANSPARENT_KEY: key_reg        = cfg_wdata;
                    default: ;
                endcase
            end

            if (item_valid && item_ready)
            begin
                if (item.opcode == OP_CURSOR)
                    cursor_words[item.cursor_index] = item.pixel_value;
                else
                    expected_beats.push_back(predict_scanout_beat(item.pixel_value));
            end

            if (result_valid && result_ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    fail_count++;
                    $display("%0t ns: result beat expected none, got %h", $time, result);
                end
                else
                begin
                    want = expected_beats.pop_front();
                    compare_field("fb_address", want.fb_address, result.fb_address);
                    compare_field("out_data", want.out_data, result.out_data);
                    compare_field("byte_count", 32'(want.byte_count),
                                  32'(result.byte_count));
                    compare_field("frame_end", 32'(want.frame_end),
                                  32'(result.frame_end));
                end
            end

            mismatches  <= fail_count;
            outstanding <= expected_beats.size();
        end
    end

endmodule

// ===== tb/sv/tb_scanout_cursor_format_convert.sv =====
`timescale 1ns / 1ps

module tb_scanout_cursor_format_convert;
    import scc_pkg::*;

    localparam int CURSOR_W     = 16;
    localparam int CURSOR_H     = 16;
    localparam int MAX_DIM      = 4096;
    localparam logic [1:0] FMT_UNUSED = 2'd3;
    localparam int IDLE_PCT     = 21;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 270;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    item_t       item         = '0;
    logic        result_ready = 1'b0;
    logic        cfg_we       = 1'b0;
    logic [2:0]  cfg_index    = REG_SCREEN_WIDTH;
    logic [31:0] cfg_wdata    = '0;
    logic        item_ready;
    logic        result_valid;
    result_t     result;

    int          mismatches;
    int          outstanding;
    int          send_idle_pct = 0;
    int          sink_idle_pct = 0;
    int          hold_req      = 0;
    int          hold_seen     = 0;
    int          cycle_count   = 0;
    logic [31:0] cursor_shadow [CURSOR_DEPTH];
    logic [31:0] key_now       = '0;

    scanout_cursor_format_convert #(
        .CURSOR_W (CURSOR_W),
        .CURSOR_H (CURSOR_H),
        .MAX_DIM  (MAX_DIM)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    scanout_beat_checker #(
        .CURSOR_W (CURSOR_W),
        .CURSOR_H (CURSOR_H),
        .MAX_DIM  (MAX_DIM)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: random back-pressure, plus a long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                result_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic send_beat(input item_t beat);
        if ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= beat;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    task automatic send_pixel(input logic [31:0] value);
        item_t beat;
        beat.opcode       = OP_PIXEL;
        beat.pixel_value  = value;
        beat.cursor_index = 8'($urandom);
        send_beat(beat);
    endtask

    task automatic load_cursor(input logic [7:0] idx, input logic [31:0] value);
        item_t beat;
        beat.opcode       = OP_CURSOR;
        beat.pixel_value  = value;
        beat.cursor_index = idx;
        cursor_shadow[idx] = value;
        send_beat(beat);
    endtask

    // Drop valid and wait until every pixel beat has come back.
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [31:0] w, input logic [31:0] h,
                                input logic [31:0] lb, input logic [1:0] fmt,
                                input logic [31:0] base, input logic [31:0] ccol,
                                input logic [31:0] crow, input logic [31:0] key);
        write_reg(REG_SCREEN_WIDTH, w);
        write_reg(REG_SCREEN_HEIGHT, h);
        write_reg(REG_LINE_BYTES, lb);
        write_reg(REG_PIXEL_FORMAT, {30'd0, fmt});
        write_reg(REG_FRAME_BASE, base);
        write_reg(REG_CURSOR_COL, ccol);
        write_reg(REG_CURSOR_ROW, crow);
        write_reg(REG_TRANSPARENT_KEY, key);
        cfg_we <= 1'b0;
        key_now = key;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        int          w;
        int          h;
        int          n;
        int          sel;
        int          phase;
        int          random_sent;
        logic [31:0] lb;
        logic [31:0] base;
        logic [31:0] ccol;
        logic [31:0] crow;
        logic [31:0] key;
        logic [31:0] value;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole cursor image; every seventh word matches the reset key.
        send_idle_pct = IDLE_PCT;
        sink_idle_pct <= IDLE_PCT;
        for (int i = 0; i < CURSOR_DEPTH; i++)
            load_cursor(8'(i), (i % 7 == 0) ? 32'h0 : $urandom);

        // Reset configuration, cursor at the origin.
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h00A5_C3E7);

        // Shrink the screen below the current column; address wraps past 2^32.
        settle();
        program_regs(3, 2, 32'h7FFF, FMT_24BPP, 32'hFFFF_FFF8, 1, 0, cursor_shadow[1]);
        repeat (6) send_pixel($urandom);

        // Zero sizes act as one pixel: every beat ends the frame.
        settle();
        program_regs(0, 0, 2, FMT_RGB565, 32'h0, 0, 0, 32'hFFFF_FFFF);
        send_pixel(32'h00F8_FCF8);
        send_pixel(32'hFF07_0307);
        send_pixel(32'h5A5A_5A5A);

        // Oversized screen, unused format code, cursor at the far corner.
        settle();
        program_regs(8191, 8191, 0, FMT_UNUSED, 32'h8000_0000, 4095, 4095, 32'h0);
        repeat (3) send_pixel($urandom);

        // Cursor column at the screen width: nothing is drawn.
        settle();
        program_regs(4, 2, 16, FMT_32BPP, 32'h0000_1000, 4, 0, 32'h0);
        load_cursor(8'd0, 32'h0);
        load_cursor(8'd255, 32'hFFFF_FFFF);
        repeat (4) send_pixel($urandom);

        phase       = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            settle();

            sel = $urandom_range(9);
            if (sel == 0)
            begin
                w = 0;
                h = $urandom_range(0, 3);
            end
            else if (sel == 1)
            begin
                w = $urandom_range(4090, 8191);
                h = 8191;
            end
            else if (sel == 2)
            begin
                w = $urandom_range(1, 8191);
                h = $urandom_range(1, 8191);
            end
            else
            begin
                w = $urandom_range(1, 20);
                h = $urandom_range(1, 6);
            end

            case ($urandom_range(3))
                0:       lb = $urandom_range(0, 32767);
                1:       lb = 2;
                2:       lb = 32767;
                default: lb = $urandom_range(2, 128);
            endcase

            base = ($urandom_range(3) == 0) ? 32'hFFFF_FF00 + $urandom_range(255) : $urandom;
            ccol = ($urandom_range(3) == 0) ? $urandom_range(0, 4095)
                                           : $urandom_range(0, (w < 24) ? w + 1 : 24);
            crow = ($urandom_range(3) == 0) ? $urandom_range(0, 4095)
                                           : $urandom_range(0, (h < 24) ? h + 1 : 24);
            case ($urandom_range(2))
                0:       key = cursor_shadow[$urandom_range(CURSOR_DEPTH - 1)];
                1:       key = 32'h0;
                default: key = $urandom;
            endcase
            program_regs(w, h, lb, 2'($urandom_range(3)), base, ccol, crow, key);

            n = $urandom_range(12, 48);
            send_idle_pct = IDLE_PCT;
            sink_idle_pct <= IDLE_PCT;
            if (phase == 2)
            begin
                // long stretch with both sides streaming
                send_idle_pct = 0;
                sink_idle_pct <= 0;
                n = 60;
            end
            else if (phase == 4)
            begin
                // hold off the result side while pixels keep coming
                send_idle_pct = 0;
                hold_req <= hold_req + 1;
                n = 40;
            end

            repeat (n)
            begin
                if ($urandom_range(9) == 0)
                begin
                    value = ($urandom_range(2) == 0) ? key_now : $urandom;
                    if ($urandom_range(1) == 0)
                        load_cursor(8'($urandom_range(0, 47)), value);
                    else
                        load_cursor(8'($urandom), value);
                end
                else
                begin
                    case ($urandom_range(7))
                        0:       send_pixel(32'h0);
                        1:       send_pixel(32'hFFFF_FFFF);
                        default: send_pixel($urandom);
                    endcase
                end
                random_sent++;
            end
            phase++;
        end

        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/scc_pkg.sv
rtl/scc_cursor_ram.sv
rtl/scanout_cursor_format_convert.sv
tb/sv/scanout_beat_checker.sv
tb/sv/tb_scanout_cursor_format_convert.sv
